// File: sv/ir_ras_pkg.sv
// ----------------------------------------------------------------------------
// IR range averaging package
// Shared widths, constants, controller states and command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ir_ras_pkg;

    // ADC and configuration
    localparam int ADC_W      = 10;
    localparam int CFG_IDX_W  = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SHORT_NEAR = 2'd0;
    localparam t_cfg_idx CFG_SHORT_FAR  = 2'd1;
    localparam t_cfg_idx CFG_LONG_NEAR  = 2'd2;
    localparam t_cfg_idx CFG_LONG_FAR   = 2'd3;

    localparam logic [ADC_W-1:0] SHORT_NEAR_RST = 10'd724;
    localparam logic [ADC_W-1:0] SHORT_FAR_RST  = 10'd204;
    localparam logic [ADC_W-1:0] LONG_NEAR_RST  = 10'd940;
    localparam logic [ADC_W-1:0] LONG_FAR_RST   = 10'd630;

    // Divider geometry: 31-bit dividend, 17-bit divisor
    localparam int DIVD_W     = 31;
    localparam int DIVS_W     = 17;
    localparam int DIV_STEP_W = $clog2(DIVD_W + 1);

    // Linearisation law, Q8 centimetres
    localparam int DEN_W  = DIVS_W + 1;
    localparam logic [DIVS_W-1:0] ADC_SCALE = 17'd125;
    localparam logic signed [DEN_W-1:0] SHORT_OFS = 18'sd5120;
    localparam logic signed [DEN_W-1:0] LONG_OFS  = 18'sd65536;
    localparam logic [DIVD_W-1:0] SHORT_NUM_Q8 = 31'd655360000;
    localparam logic [DIVD_W-1:0] LONG_NUM_Q8  = 31'd1599078400;

    localparam int SQ_W = 16;   // short sample, Q8
    localparam int LQ_W = 17;   // long sample, Q8
    localparam logic [SQ_W-1:0] SHORT_NEAR_Q8 = 16'd7680;
    localparam logic [SQ_W-1:0] SHORT_FAR_Q8  = 16'd38400;
    localparam logic [LQ_W-1:0] LONG_NEAR_Q8  = 17'd0;
    localparam logic [LQ_W-1:0] LONG_FAR_Q8   = 17'd128000;

    localparam int SSUM_W = 21;
    localparam int LSUM_W = 23;

    // Batch average by rounded-up reciprocal, exact for sums below 2^23
    // and batch sizes up to 32
    localparam int AVG_SHIFT = 29;
    localparam int RCP_W     = AVG_SHIFT + 1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIN_GO,
        ST_LIN_WAIT,
        ST_ACC,
        ST_AVG,
        ST_LOAD
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic ready;
        logic cap;
        logic div_go;
        logic avg;
        logic acc;
        logic load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_busy;
        logic batch_full;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: sv/ir_ras_in_if.sv
// ----------------------------------------------------------------------------
// IR range sample channel
// Valid/ready channel carrying one reading from each sensor.
// ----------------------------------------------------------------------------
`default_nettype none

interface ir_ras_in_if;
    logic                          valid;
    logic                          ready;
    logic [ir_ras_pkg::ADC_W-1:0]  short_sample;
    logic [ir_ras_pkg::ADC_W-1:0]  long_sample;

    modport source (output valid, output short_sample, output long_sample, input ready);
    modport sink   (input valid, input short_sample, input long_sample, output ready);
endinterface

`default_nettype wire

// File: sv/ir_ras_out_if.sv
// ----------------------------------------------------------------------------
// IR range result channel
// Valid/ready channel carrying the averaged and chosen distances.
// ----------------------------------------------------------------------------
`default_nettype none

interface ir_ras_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] distance_cm;
    logic [7:0] short_avg_cm;
    logic [8:0] long_avg_cm;
    logic       used_long;

    modport source (output valid, output distance_cm, output short_avg_cm,
                    output long_avg_cm, output used_long, input ready);
    modport sink   (input valid, input distance_cm, input short_avg_cm,
                    input long_avg_cm, input used_long, output ready);
endinterface

`default_nettype wire

// File: sv/ir_ras_div.sv
// ----------------------------------------------------------------------------
// IR range sequential divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_ras_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [ir_ras_pkg::DIVD_W-1:0]     i_dividend,
    input  wire logic [ir_ras_pkg::DIVS_W-1:0]     i_divisor,
    output logic                                   o_busy,
    output logic [ir_ras_pkg::DIVD_W-1:0]          o_quotient
);

    logic [ir_ras_pkg::DIVD_W-1:0]     r_quo, n_quo;
    logic [ir_ras_pkg::DIVS_W-1:0]     r_rem, n_rem;
    logic [ir_ras_pkg::DIVS_W-1:0]     r_dvs;
    logic [ir_ras_pkg::DIV_STEP_W-1:0] r_cnt;

    logic [ir_ras_pkg::DIVS_W:0] w_part;
    logic [ir_ras_pkg::DIVS_W:0] w_diff;
    logic                        w_ge;

    // one restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        w_part = {r_rem, r_quo[ir_ras_pkg::DIVD_W-1]};
        w_ge   = (w_part >= {1'b0, r_dvs});
        w_diff = w_part - {1'b0, r_dvs};
        n_rem  = w_ge ? w_diff[ir_ras_pkg::DIVS_W-1:0] : w_part[ir_ras_pkg::DIVS_W-1:0];
        n_quo  = {r_quo[ir_ras_pkg::DIVD_W-2:0], w_ge};
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= ir_ras_pkg::DIV_STEP_W'(ir_ras_pkg::DIVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: sv/ir_ras_ctrl.sv
// ----------------------------------------------------------------------------
// IR range controller
// Sequences capture, linearisation, accumulation, averaging and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_ras_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire ir_ras_pkg::t_status i_status,
    output ir_ras_pkg::t_cmd         o_cmd
);

    ir_ras_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ir_ras_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ir_ras_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = ir_ras_pkg::ST_LIN_GO;
            end
            ir_ras_pkg::ST_LIN_GO:   n_state = ir_ras_pkg::ST_LIN_WAIT;
            ir_ras_pkg::ST_LIN_WAIT: begin
                if (!i_status.div_busy) n_state = ir_ras_pkg::ST_ACC;
            end
            ir_ras_pkg::ST_ACC: begin
                n_state = i_status.batch_full ? ir_ras_pkg::ST_AVG : ir_ras_pkg::ST_IDLE;
            end
            ir_ras_pkg::ST_AVG:      n_state = ir_ras_pkg::ST_LOAD;
            ir_ras_pkg::ST_LOAD: begin
                if (i_status.out_free) n_state = ir_ras_pkg::ST_IDLE;
            end
            default: n_state = ir_ras_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ir_ras_pkg::ST_IDLE: begin
                o_cmd.ready = 1'b1;
                o_cmd.cap   = i_in_valid;
            end
            ir_ras_pkg::ST_LIN_GO:   o_cmd.div_go = 1'b1;
            ir_ras_pkg::ST_LIN_WAIT: o_cmd = '0;
            ir_ras_pkg::ST_ACC:      o_cmd.acc = 1'b1;
            ir_ras_pkg::ST_AVG:      o_cmd.avg = 1'b1;
            ir_ras_pkg::ST_LOAD:     o_cmd.load = i_status.out_free;
            default:                 o_cmd = '0;
        endcase
    end

    // a result is never loaded over one still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_status.out_free)
        else $error("result loaded while output register occupied");

    // the divider is only started when idle
    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_go |-> !i_status.div_busy)
        else $error("divider restarted while busy");

    // a captured transaction always starts a linearisation
    a_cap_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cap |=> o_cmd.div_go && !o_cmd.avg)
        else $error("capture not followed by linearisation start");

endmodule

`default_nettype wire

// File: sv/ir_ras_dp.sv
// ----------------------------------------------------------------------------
// IR range datapath
// Limit registers, sample capture, two dividers, sums and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_ras_dp #(
    parameter int SAMPLES_PER_RESULT = 10
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire ir_ras_pkg::t_cmd                    i_cmd,
    output ir_ras_pkg::t_status                      o_status,
    input  wire logic                                i_cfg_we,
    input  wire ir_ras_pkg::t_cfg_idx                i_cfg_idx,
    input  wire logic [ir_ras_pkg::ADC_W-1:0]        i_cfg_data,
    input  wire logic [ir_ras_pkg::ADC_W-1:0]        i_short_sample,
    input  wire logic [ir_ras_pkg::ADC_W-1:0]        i_long_sample,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [8:0]                               o_distance_cm,
    output logic [7:0]                               o_short_avg_cm,
    output logic [8:0]                               o_long_avg_cm,
    output logic                                     o_used_long
);

    localparam int CNT_W  = $clog2(SAMPLES_PER_RESULT + 1);
    localparam int SPRD_W = ir_ras_pkg::SSUM_W + ir_ras_pkg::RCP_W;
    localparam int LPRD_W = ir_ras_pkg::LSUM_W + ir_ras_pkg::RCP_W;

    // reciprocal of the batch size, rounded up
    localparam longint RCP_NUM = (longint'(1) << ir_ras_pkg::AVG_SHIFT)
                                 + longint'(SAMPLES_PER_RESULT) - 1;
    localparam logic [ir_ras_pkg::RCP_W-1:0] AVG_RCP =
        ir_ras_pkg::RCP_W'(RCP_NUM / longint'(SAMPLES_PER_RESULT));

    logic [ir_ras_pkg::ADC_W-1:0] r_short_near, r_short_far, r_long_near, r_long_far;
    logic [ir_ras_pkg::ADC_W-1:0] r_xs, r_xl;
    logic [ir_ras_pkg::SSUM_W-1:0] r_short_sum;
    logic [ir_ras_pkg::LSUM_W-1:0] r_long_sum;
    logic [CNT_W-1:0]              r_count;
    logic [ir_ras_pkg::SQ_W-1:0]   r_savg;
    logic [ir_ras_pkg::LQ_W-1:0]   r_lavg;
    logic                          r_out_valid;
    logic [8:0]                    r_dist, r_lcm;
    logic [7:0]                    r_scm;
    logic                          r_used;

    logic [ir_ras_pkg::DIVS_W-1:0]       w_sprod, w_lprod;
    logic signed [ir_ras_pkg::DEN_W-1:0] w_sden, w_lden;
    logic [ir_ras_pkg::DIVD_W-1:0]       w_squo, w_lquo;
    logic                                w_sbusy, w_lbusy;
    logic [ir_ras_pkg::SQ_W-1:0]         w_sq8;
    logic [ir_ras_pkg::LQ_W-1:0]         w_lq8;
    logic [SPRD_W-1:0]                   w_sprd;
    logic [LPRD_W-1:0]                   w_lprd;
    logic                                w_out_free, w_used;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_near <= ir_ras_pkg::SHORT_NEAR_RST;
            r_short_far  <= ir_ras_pkg::SHORT_FAR_RST;
            r_long_near  <= ir_ras_pkg::LONG_NEAR_RST;
            r_long_far   <= ir_ras_pkg::LONG_FAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ir_ras_pkg::CFG_SHORT_NEAR: r_short_near <= i_cfg_data;
                ir_ras_pkg::CFG_SHORT_FAR:  r_short_far  <= i_cfg_data;
                ir_ras_pkg::CFG_LONG_NEAR:  r_long_near  <= i_cfg_data;
                ir_ras_pkg::CFG_LONG_FAR:   r_long_far   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_xs <= i_short_sample;
            r_xl <= i_long_sample;
        end
    end

    // denominators 125x - offset
    always_comb begin
        w_sprod = ir_ras_pkg::DIVS_W'(r_xs) * ir_ras_pkg::ADC_SCALE;
        w_lprod = ir_ras_pkg::DIVS_W'(r_xl) * ir_ras_pkg::ADC_SCALE;
        w_sden  = $signed({1'b0, w_sprod}) - ir_ras_pkg::SHORT_OFS;
        w_lden  = $signed({1'b0, w_lprod}) - ir_ras_pkg::LONG_OFS;
    end

    ir_ras_div u_short_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (ir_ras_pkg::SHORT_NUM_Q8),
        .i_divisor  (w_sden[ir_ras_pkg::DIVS_W-1:0]),
        .o_busy     (w_sbusy),
        .o_quotient (w_squo)
    );

    ir_ras_div u_long_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (ir_ras_pkg::LONG_NUM_Q8),
        .i_divisor  (w_lden[ir_ras_pkg::DIVS_W-1:0]),
        .o_busy     (w_lbusy),
        .o_quotient (w_lquo)
    );

    // clamp selection: near limit first, then far limit, bad denominator, saturation
    always_comb begin
        if (r_xs >= r_short_near) begin
            w_sq8 = ir_ras_pkg::SHORT_NEAR_Q8;
        end else if (r_xs <= r_short_far || w_sden <= 0 ||
                     w_squo > ir_ras_pkg::DIVD_W'(ir_ras_pkg::SHORT_FAR_Q8)) begin
            w_sq8 = ir_ras_pkg::SHORT_FAR_Q8;
        end else begin
            w_sq8 = w_squo[ir_ras_pkg::SQ_W-1:0];
        end

        if (r_xl >= r_long_near) begin
            w_lq8 = ir_ras_pkg::LONG_NEAR_Q8;
        end else if (r_xl <= r_long_far || w_lden <= 0 ||
                     w_lquo > ir_ras_pkg::DIVD_W'(ir_ras_pkg::LONG_FAR_Q8)) begin
            w_lq8 = ir_ras_pkg::LONG_FAR_Q8;
        end else begin
            w_lq8 = w_lquo[ir_ras_pkg::LQ_W-1:0];
        end
    end

    // batch sums and sample count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_short_sum <= '0;
            r_long_sum  <= '0;
            r_count     <= '0;
        end else if (i_cmd.acc) begin
            r_short_sum <= r_short_sum + ir_ras_pkg::SSUM_W'(w_sq8);
            r_long_sum  <= r_long_sum + ir_ras_pkg::LSUM_W'(w_lq8);
            r_count     <= r_count + 1'b1;
        end
    end

    // batch averages: sum times reciprocal, scaled back down
    always_comb begin
        w_sprd = SPRD_W'(r_short_sum) * SPRD_W'(AVG_RCP);
        w_lprd = LPRD_W'(r_long_sum) * LPRD_W'(AVG_RCP);
    end

    // every sample is at most the far distance, so the averages fit a sample
    always_ff @(posedge i_clk) begin
        if (i_cmd.avg) begin
            r_savg <= w_sprd[ir_ras_pkg::AVG_SHIFT +: ir_ras_pkg::SQ_W];
            r_lavg <= w_lprd[ir_ras_pkg::AVG_SHIFT +: ir_ras_pkg::LQ_W];
        end
    end

    // choice: long average when short average sits exactly at far distance
    assign w_used = (r_savg == ir_ras_pkg::SHORT_FAR_Q8);

    // output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scm  <= r_savg[15:8];
            r_lcm  <= r_lavg[16:8];
            r_used <= w_used;
            r_dist <= w_used ? r_lavg[16:8] : {1'b0, r_savg[15:8]};
        end
    end

    assign o_status.div_busy   = w_sbusy | w_lbusy;
    assign o_status.batch_full = (r_count == CNT_W'(SAMPLES_PER_RESULT - 1));
    assign o_status.out_free   = w_out_free;

    assign o_out_valid    = r_out_valid;
    assign o_distance_cm  = r_dist;
    assign o_short_avg_cm = r_scm;
    assign o_long_avg_cm  = r_lcm;
    assign o_used_long    = r_used;

endmodule

`default_nettype wire

// File: sv/ir_range_average_select_unit.sv
// ----------------------------------------------------------------------------
// IR range average and select unit
// Linearises two IR range readings, averages batches and picks a distance.
// ----------------------------------------------------------------------------
// Samples: a new transaction is taken only in idle, after two 31-step
//   restoring dividers running side by side for the reciprocal law finish.
// Batch end: the closing sample then passes an averaging state, which scales
//   the sums by the batch reciprocal, and a load that waits for a free output.
// Reset (synchronous, active low): limits return to defaults, sums and
//   count clear, no result pending.
`default_nettype none

module ir_range_average_select_unit #(
    parameter int SAMPLES_PER_RESULT = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    ir_ras_in_if.sink                           i_smp,
    ir_ras_out_if.source                        o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [ir_ras_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [ir_ras_pkg::ADC_W-1:0]   i_cfg_data
);

    ir_ras_pkg::t_cmd    w_cmd;
    ir_ras_pkg::t_status w_status;

    ir_ras_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ir_ras_dp #(
        .SAMPLES_PER_RESULT (SAMPLES_PER_RESULT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_short_sample (i_smp.short_sample),
        .i_long_sample  (i_smp.long_sample),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_distance_cm  (o_res.distance_cm),
        .o_short_avg_cm (o_res.short_avg_cm),
        .o_long_avg_cm  (o_res.long_avg_cm),
        .o_used_long    (o_res.used_long)
    );

    assign i_smp.ready = w_cmd.ready;

endmodule

`default_nettype wire
